// File: design/gdbc_pkg.sv
// ----------------------------------------------------------------------------
// gdbc_pkg: shared types and constants of the burst capture core
// Request and result payloads, command codes, back-end states, defaults.
// ----------------------------------------------------------------------------
package gdbc_pkg;

  // Default sizing, handed to the top level parameters
  localparam int unsigned CAPTURE_BYTES_DEF = 4096;
  localparam int unsigned BURST_SLOTS_DEF   = 64;
  localparam int unsigned CHUNK_BYTES_DEF   = 16;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Reset value of the gap register (ms)
  localparam logic [15:0] GAP_MS_RESET = 16'd20;

  // Command codes of an input request
  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_READOUT = 1'b1
  } cmd_e;

  // Input request payload
  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx_byte;
    logic [31:0] time_ms;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [6:0]  burst_number;
    logic [31:0] burst_start_ms;
    logic [11:0] byte_offset;
    logic [12:0] burst_length;
    logic [31:0] recv_count;
    logic [12:0] stored_count;
    logic [6:0]  burst_total;
    logic        byte_lost;
    logic        burst_lost;
    logic        last;
  } out_item_t;

  // Classified request queued between front and back
  typedef struct packed {
    cmd_e        kind;
    logic [7:0]  rx_byte;
    logic [31:0] time_ms;
  } req_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_LOOK,
    BK_EMIT,
    BK_STATUS
  } back_state_e;

endpackage

// File: design/gdbc_stream_if.sv
// ----------------------------------------------------------------------------
// gdbc_stream_if: valid/ready stream channel
// Carries one payload per request; source drives valid and payload.
// ----------------------------------------------------------------------------
interface gdbc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/gap_delimited_burst_capture_core.sv
// ----------------------------------------------------------------------------
// gap_delimited_burst_capture_core: gap-delimited burst capture buffer
// Captures timestamped bytes into bursts and reads them back in chunks.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries requests: cmd = capture (rx_byte at time_ms) or readout.
//   out_o carries results; a readout yields up to CHUNK_BYTES data results
//   followed by one status result with last set. A capture yields nothing.
//   gap_we_i/gap_wdata_i write the gap register (reset 20 ms); the user must
//   do so only while idle, as the block itself does not enforce it.
// Flow:
//   Requests pass a two-entry queue; captures are handled in the idle state,
//   so captures sustain one per cycle while no readout is busy in the engine.
//   A readout leaves the queue, then takes a table fetch and a length check
//   per burst record examined, a read through the capture memory read port
//   per data byte and then the status result. A readout with nothing stored
//   goes straight to its status result.
// Reset:
//   Counters, flags and pointers clear; memory contents are left as is and
//   never read before being written. No clearing pass is needed.
// Stall:
//   Results sit in an output register; a readout holds while a held result
//   is not taken; the front keeps taking requests until its queue is full.
// ----------------------------------------------------------------------------
module gap_delimited_burst_capture_core #(
  parameter int unsigned CAPTURE_BYTES = gdbc_pkg::CAPTURE_BYTES_DEF,
  parameter int unsigned BURST_SLOTS   = gdbc_pkg::BURST_SLOTS_DEF,
  parameter int unsigned CHUNK_BYTES   = gdbc_pkg::CHUNK_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gdbc_stream_if.sink   in_i,
  gdbc_stream_if.source out_o,
  input  logic          gap_we_i,
  input  logic [15:0]   gap_wdata_i
);

  logic [15:0]    gap_q;
  gdbc_pkg::req_t req;
  logic           req_valid;
  logic           req_ready;

  // Gap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= gdbc_pkg::GAP_MS_RESET;
    end else if (gap_we_i) begin
      gap_q <= gap_wdata_i;
    end
  end

  // Request intake
  gdbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .req_o       (req),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready)
  );

  // Capture and readout engine
  gdbc_back #(
    .CAPTURE_BYTES (CAPTURE_BYTES),
    .BURST_SLOTS   (BURST_SLOTS),
    .CHUNK_BYTES   (CHUNK_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gap_i       (gap_q),
    .req_i       (req),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .res_o       (out_o)
  );

endmodule

// File: design/gdbc_front.sv
// ----------------------------------------------------------------------------
// gdbc_front: request intake and queue
// Accepts input requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module gdbc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  gdbc_stream_if.sink         in_i,
  output gdbc_pkg::req_t      req_o,
  output logic                req_valid_o,
  input  logic                req_ready_i
);

  localparam int unsigned QW = (gdbc_pkg::QUEUE_DEPTH > 1) ? $clog2(gdbc_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(gdbc_pkg::QUEUE_DEPTH + 1);

  gdbc_pkg::req_t q_mem [gdbc_pkg::QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           push, pop;
  gdbc_pkg::req_t req_new;

  // Classify the incoming request
  assign req_new.kind    = gdbc_pkg::cmd_e'(in_i.payload.cmd);
  assign req_new.rx_byte = in_i.payload.rx_byte;
  assign req_new.time_ms = in_i.payload.time_ms;

  assign in_i.ready  = (count_q < CW'(gdbc_pkg::QUEUE_DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign req_valid_o = (count_q != '0);
  assign pop         = req_valid_o && req_ready_i;
  assign req_o       = q_mem[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QW'(gdbc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QW'(gdbc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= req_new;
    end
  end

endmodule

// File: design/gdbc_back.sv
// ----------------------------------------------------------------------------
// gdbc_back: capture and readout engine
// Stores bytes and burst records, walks bursts for readout, owns the result
// register.
// ----------------------------------------------------------------------------
module gdbc_back #(
  parameter int unsigned CAPTURE_BYTES = gdbc_pkg::CAPTURE_BYTES_DEF,
  parameter int unsigned BURST_SLOTS   = gdbc_pkg::BURST_SLOTS_DEF,
  parameter int unsigned CHUNK_BYTES   = gdbc_pkg::CHUNK_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    gap_i,
  input  gdbc_pkg::req_t req_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  gdbc_stream_if.source  res_o
);

  localparam int unsigned AW = $clog2(CAPTURE_BYTES);
  localparam int unsigned SW = $clog2(CAPTURE_BYTES + 1);
  localparam int unsigned TW = (BURST_SLOTS > 1) ? $clog2(BURST_SLOTS) : 1;
  localparam int unsigned BW = $clog2(BURST_SLOTS + 1);
  localparam int unsigned CW = $clog2(CHUNK_BYTES + 1);

  // Memories
  logic [7:0]    capture_mem [CAPTURE_BYTES];
  logic [AW-1:0] off_tab     [BURST_SLOTS];
  logic [SW-1:0] len_tab     [BURST_SLOTS];
  logic [31:0]   time_tab    [BURST_SLOTS];

  // Control and status registers
  gdbc_pkg::back_state_e state_q, state_d;
  logic [SW-1:0] stored_q, stored_d;
  logic [BW-1:0] burst_cnt_q, burst_cnt_d;
  logic          open_q, open_d;
  logic          seen_q, seen_d;
  logic [31:0]   first_q, first_d;
  logic [31:0]   prev_q, prev_d;
  logic [31:0]   recv_cnt_q, recv_cnt_d;
  logic          ddrop_q, ddrop_d;
  logic          bdrop_q, bdrop_d;
  logic [SW-1:0] cur_len_q, cur_len_d;
  logic [BW-1:0] rd_burst_q, rd_burst_d;
  logic [SW-1:0] rd_off_q, rd_off_d;
  logic [BW-1:0] tries_q, tries_d;
  logic [CW-1:0] left_q, left_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;

  // Registered memory read data
  logic [7:0]    rdata_q;
  logic [AW-1:0] off_rd_q;
  logic [SW-1:0] len_rd_q;
  logic [31:0]   time_rd_q;

  // Result register
  logic                out_valid_q, out_valid_d;
  gdbc_pkg::out_item_t out_q, out_d;
  logic                out_free;

  // Capture datapath
  logic          do_capture;
  logic [31:0]   gap_elapsed, rel_time;
  logic          need_new, room_burst, room_mem, open_new, store;
  logic [TW-1:0] len_waddr;
  logic [SW-1:0] len_wdata;

  // Readout datapath
  logic          mem_re, tab_re;
  logic [AW-1:0] mem_raddr;
  logic [TW-1:0] tab_raddr;
  logic          wrap, skip, rd_done;
  logic [SW-1:0] remain;
  logic [SW-1:0] rd_off_inc;
  logic [BW-1:0] tries_inc;

  assign out_free    = !out_valid_q || res_o.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.payload = out_q;

  // Capture decisions
  assign gap_elapsed = req_i.time_ms - prev_q;
  assign rel_time    = seen_q ? (req_i.time_ms - first_q) : 32'd0;
  assign need_new    = !open_q || (gap_elapsed > {16'd0, gap_i});
  assign room_burst  = (burst_cnt_q < BW'(BURST_SLOTS));
  assign room_mem    = (stored_q < SW'(CAPTURE_BYTES));
  assign open_new    = need_new && room_burst && room_mem;
  assign store       = room_mem && (open_new || !need_new);
  assign len_waddr   = open_new ? burst_cnt_q[TW-1:0] : TW'(burst_cnt_q - BW'(1));
  assign len_wdata   = open_new ? SW'(1) : cur_len_q + SW'(1);

  // Readout decisions
  assign wrap       = (rd_burst_q >= burst_cnt_q);
  assign skip       = (rd_off_q >= len_rd_q);
  assign remain     = len_rd_q - rd_off_q;
  assign rd_off_inc = rd_off_q + SW'(1);
  assign tries_inc  = tries_q + BW'(1);
  assign rd_done    = (recv_cnt_q == 32'd0) || (burst_cnt_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gdbc_pkg::BK_IDLE: begin
        if (req_valid_i && req_i.kind == gdbc_pkg::CMD_READOUT) begin
          state_d = rd_done ? gdbc_pkg::BK_STATUS : gdbc_pkg::BK_CHECK;
        end
      end
      gdbc_pkg::BK_CHECK: begin
        state_d = gdbc_pkg::BK_LOOK;
      end
      gdbc_pkg::BK_LOOK: begin
        if (!skip) begin
          state_d = gdbc_pkg::BK_EMIT;
        end else if (tries_inc >= burst_cnt_q) begin
          state_d = gdbc_pkg::BK_STATUS;
        end else begin
          state_d = gdbc_pkg::BK_CHECK;
        end
      end
      gdbc_pkg::BK_EMIT: begin
        if (out_free && left_q <= CW'(1)) begin
          state_d = gdbc_pkg::BK_STATUS;
        end
      end
      gdbc_pkg::BK_STATUS: begin
        if (out_free) begin
          state_d = gdbc_pkg::BK_IDLE;
        end
      end
      default: state_d = gdbc_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    req_ready_o = 1'b0;
    do_capture  = 1'b0;
    stored_d    = stored_q;
    burst_cnt_d = burst_cnt_q;
    open_d      = open_q;
    seen_d      = seen_q;
    first_d     = first_q;
    prev_d      = prev_q;
    recv_cnt_d  = recv_cnt_q;
    ddrop_d     = ddrop_q;
    bdrop_d     = bdrop_q;
    cur_len_d   = cur_len_q;
    rd_burst_d  = rd_burst_q;
    rd_off_d    = rd_off_q;
    tries_d     = tries_q;
    left_d      = left_q;
    rd_addr_d   = rd_addr_q;
    mem_re      = 1'b0;
    mem_raddr   = rd_addr_q;
    tab_re      = 1'b0;
    tab_raddr   = rd_burst_q[TW-1:0];
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;
    case (state_q)
      gdbc_pkg::BK_IDLE: begin
        if (req_valid_i) begin
          req_ready_o = 1'b1;
          if (req_i.kind == gdbc_pkg::CMD_CAPTURE) begin
            do_capture = 1'b1;
            recv_cnt_d = recv_cnt_q + 32'd1;
            seen_d     = 1'b1;
            if (!seen_q) begin
              first_d = req_i.time_ms;
            end
            prev_d = req_i.time_ms;
            if (need_new) begin
              open_d = open_new;
              if (!open_new) begin
                bdrop_d = 1'b1;
              end
            end
            if (open_new) begin
              burst_cnt_d = burst_cnt_q + BW'(1);
            end
            if (store) begin
              stored_d  = stored_q + SW'(1);
              cur_len_d = len_wdata;
            end else begin
              ddrop_d = 1'b1;
            end
          end else begin
            tries_d = '0;
          end
        end
      end
      gdbc_pkg::BK_CHECK: begin
        // Wrap the pointer past the last burst, then fetch its record
        tab_re = 1'b1;
        if (wrap) begin
          rd_burst_d = '0;
          rd_off_d   = '0;
          tab_raddr  = '0;
        end
      end
      gdbc_pkg::BK_LOOK: begin
        if (skip) begin
          rd_burst_d = rd_burst_q + BW'(1);
          rd_off_d   = '0;
          tries_d    = tries_inc;
        end else begin
          left_d    = (32'(remain) > 32'(CHUNK_BYTES)) ? CW'(CHUNK_BYTES) : CW'(remain);
          mem_re    = 1'b1;
          mem_raddr = off_rd_q + AW'(rd_off_q);
          rd_addr_d = mem_raddr;
        end
      end
      gdbc_pkg::BK_EMIT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.data_valid     = 1'b1;
          out_d.data_byte      = rdata_q;
          out_d.burst_number   = 7'(rd_burst_q + BW'(1));
          out_d.burst_start_ms = time_rd_q;
          out_d.byte_offset    = 12'(rd_off_q);
          out_d.burst_length   = 13'(len_rd_q);
          out_d.recv_count     = recv_cnt_q;
          out_d.stored_count   = 13'(stored_q);
          out_d.burst_total    = 7'(burst_cnt_q);
          out_d.byte_lost      = ddrop_q;
          out_d.burst_lost     = bdrop_q;
          out_d.last           = 1'b0;
          rd_off_d             = rd_off_inc;
          left_d               = left_q - CW'(1);
          if (left_q > CW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = rd_addr_q + AW'(1);
            rd_addr_d = mem_raddr;
          end else if (rd_off_inc >= len_rd_q) begin
            rd_burst_d = rd_burst_q + BW'(1);
            rd_off_d   = '0;
          end
        end
      end
      gdbc_pkg::BK_STATUS: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.recv_count     = recv_cnt_q;
          out_d.stored_count   = 13'(stored_q);
          out_d.burst_total    = 7'(burst_cnt_q);
          out_d.byte_lost      = ddrop_q;
          out_d.burst_lost     = bdrop_q;
          out_d.last           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gdbc_pkg::BK_IDLE;
      stored_q    <= '0;
      burst_cnt_q <= '0;
      open_q      <= 1'b0;
      seen_q      <= 1'b0;
      first_q     <= '0;
      prev_q      <= '0;
      recv_cnt_q  <= '0;
      ddrop_q     <= 1'b0;
      bdrop_q     <= 1'b0;
      cur_len_q   <= '0;
      rd_burst_q  <= '0;
      rd_off_q    <= '0;
      tries_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stored_q    <= stored_d;
      burst_cnt_q <= burst_cnt_d;
      open_q      <= open_d;
      seen_q      <= seen_d;
      first_q     <= first_d;
      prev_q      <= prev_d;
      recv_cnt_q  <= recv_cnt_d;
      ddrop_q     <= ddrop_d;
      bdrop_q     <= bdrop_d;
      cur_len_q   <= cur_len_d;
      rd_burst_q  <= rd_burst_d;
      rd_off_q    <= rd_off_d;
      tries_q     <= tries_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    out_q     <= out_d;
  end

  // Capture memory
  always_ff @(posedge clk_i) begin
    if (do_capture && store) begin
      capture_mem[stored_q[AW-1:0]] <= req_i.rx_byte;
    end
    if (mem_re) begin
      rdata_q <= capture_mem[mem_raddr];
    end
  end

  // Burst start offset and start time tables
  always_ff @(posedge clk_i) begin
    if (do_capture && open_new) begin
      off_tab[burst_cnt_q[TW-1:0]]  <= stored_q[AW-1:0];
      time_tab[burst_cnt_q[TW-1:0]] <= rel_time;
    end
    if (tab_re) begin
      off_rd_q  <= off_tab[tab_raddr];
      time_rd_q <= time_tab[tab_raddr];
    end
  end

  // Burst length table
  always_ff @(posedge clk_i) begin
    if (do_capture && store) begin
      len_tab[len_waddr] <= len_wdata;
    end
    if (tab_re) begin
      len_rd_q <= len_tab[tab_raddr];
    end
  end

`ifndef SYNTHESIS
  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= SW'(CAPTURE_BYTES))
    else $error("capture fill count beyond memory size");

  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_cnt_q <= BW'(BURST_SLOTS))
    else $error("burst count beyond table size");

  a_open_has_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (burst_cnt_q != '0))
    else $error("open burst without a table entry");

  a_chunk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= CW'(CHUNK_BYTES))
    else $error("chunk byte count beyond chunk size");

  a_status_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gdbc_pkg::BK_STATUS && out_free) |=> (out_valid_q && out_q.last))
    else $error("status result not presented after readout");
`endif

endmodule

// File: test/gap_delimited_burst_capture_core_test.sv
// ----------------------------------------------------------------------------
// gap_delimited_burst_capture_core_test: self-checking bench of the capture core
// Drives capture and readout requests with random idling on both channels,
// predicts every chunk and status result with an internal copy of the burst
// bookkeeping, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module gap_delimited_burst_capture_core_test;

  localparam int unsigned MEM_BYTES       = gdbc_pkg::CAPTURE_BYTES_DEF;
  localparam int unsigned SLOTS           = gdbc_pkg::BURST_SLOTS_DEF;
  localparam int unsigned CHUNK           = gdbc_pkg::CHUNK_BYTES_DEF;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS    = 180;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        gap_we = 1'b0;
  logic [15:0] gap_wdata = 16'd0;

  gdbc_stream_if #(.payload_t(gdbc_pkg::in_item_t))  req_ch ();
  gdbc_stream_if #(.payload_t(gdbc_pkg::out_item_t)) res_ch ();

  gap_delimited_burst_capture_core #(
    .CAPTURE_BYTES(MEM_BYTES),
    .BURST_SLOTS  (SLOTS),
    .CHUNK_BYTES  (CHUNK)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_ch.sink),
    .out_o      (res_ch.source),
    .gap_we_i   (gap_we),
    .gap_wdata_i(gap_wdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Burst bookkeeping mirror
  logic [7:0]  cap_bytes [MEM_BYTES];
  int unsigned tbl_start [SLOTS];
  int unsigned tbl_len   [SLOTS];
  logic [31:0] tbl_stamp [SLOTS];
  int unsigned n_stored   = 0;
  int unsigned n_bursts   = 0;
  bit          burst_open = 1'b0;
  bit          got_first  = 1'b0;
  logic [31:0] t_first    = '0;
  logic [31:0] t_last     = '0;
  logic [31:0] n_received = '0;
  bit          drop_data  = 1'b0;
  bit          drop_burst = 1'b0;
  int unsigned rd_burst   = 0;
  int unsigned rd_off     = 0;
  logic [15:0] gap_reg    = gdbc_pkg::GAP_MS_RESET;

  gdbc_pkg::out_item_t chunk_results_q [$];
  int unsigned failures      = 0;
  int unsigned idle_cycles   = 0;
  logic [31:0] stamp         = '0;
  bit          no_idle       = 1'b0;
  bit          hold_off_req  = 1'b0;

  // Result carrying the current status fields
  function automatic gdbc_pkg::out_item_t build_chunk_result(bit dv, logic [7:0] value,
      int unsigned num, logic [31:0] start, int unsigned off, int unsigned len, bit lst);
    gdbc_pkg::out_item_t r;
    r.data_valid     = dv;
    r.data_byte      = value;
    r.burst_number   = num[6:0];
    r.burst_start_ms = start;
    r.byte_offset    = off[11:0];
    r.burst_length   = len[12:0];
    r.recv_count     = n_received;
    r.stored_count   = n_stored[12:0];
    r.burst_total    = n_bursts[6:0];
    r.byte_lost      = drop_data;
    r.burst_lost     = drop_burst;
    r.last           = lst;
    return r;
  endfunction

  // Store one byte, opening a burst when the gap is exceeded
  function automatic void predict_capture(logic [7:0] value, logic [31:0] now);
    logic [31:0] since;
    n_received = n_received + 32'd1;
    if (!got_first) begin
      got_first = 1'b1;
      t_first   = now;
    end
    since = now - t_last;
    if (!burst_open || since > {16'd0, gap_reg}) begin
      burst_open = 1'b0;
      if (n_bursts < SLOTS && n_stored < MEM_BYTES) begin
        tbl_start[n_bursts] = n_stored;
        tbl_len[n_bursts]   = 0;
        tbl_stamp[n_bursts] = now - t_first;
        n_bursts++;
        burst_open = 1'b1;
      end else begin
        drop_burst = 1'b1;
      end
    end
    if (burst_open && n_stored < MEM_BYTES && n_bursts > 0) begin
      cap_bytes[n_stored] = value;
      n_stored++;
      tbl_len[n_bursts-1]++;
    end else begin
      drop_data = 1'b1;
    end
    t_last = now;
  endfunction

  // Next chunk, round-robin over bursts, then the closing status
  function automatic void predict_readout();
    int unsigned tries, len, shown;
    if (n_received != 0 && n_bursts != 0) begin
      for (tries = 0; tries < n_bursts; tries++) begin
        if (rd_burst >= n_bursts) begin
          rd_burst = 0;
          rd_off   = 0;
        end
        len = tbl_len[rd_burst];
        if (rd_off >= len) begin
          rd_burst++;
          rd_off = 0;
          continue;
        end
        shown = (len - rd_off > CHUNK) ? CHUNK : len - rd_off;
        for (int unsigned i = 0; i < shown; i++) begin
          chunk_results_q.push_back(build_chunk_result(1'b1,
              cap_bytes[tbl_start[rd_burst] + rd_off + i], rd_burst + 1,
              tbl_stamp[rd_burst], rd_off + i, len, 1'b0));
        end
        rd_off += shown;
        if (rd_off >= len) begin
          rd_burst++;
          rd_off = 0;
        end
        break;
      end
    end
    chunk_results_q.push_back(build_chunk_result(1'b0, 8'd0, 0, 32'd0, 0, 0, 1'b1));
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  // Send one request; enter and leave at a falling edge
  task automatic send_request(gdbc_pkg::in_item_t item);
    repeat (pick_gap()) @(negedge clk_i);
    req_ch.payload = item;
    req_ch.valid   = 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    if (item.cmd == gdbc_pkg::CMD_CAPTURE) predict_capture(item.rx_byte, item.time_ms);
    else predict_readout();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
  endtask

  task automatic send_capture_at(logic [7:0] value, logic [31:0] t);
    gdbc_pkg::in_item_t item;
    item.cmd     = gdbc_pkg::CMD_CAPTURE;
    item.rx_byte = value;
    item.time_ms = t;
    stamp        = t;
    send_request(item);
  endtask

  // Capture with a step that stays in the burst or opens a new one
  task automatic send_capture(bit open_new, bit at_edge);
    logic [31:0] step;
    if (open_new)
      step = {16'd0, gap_reg} + 32'd1 + (at_edge ? 32'd0 : $urandom_range(100000));
    else
      step = at_edge ? {16'd0, gap_reg} : $urandom_range(gap_reg);
    send_capture_at(8'($urandom_range(255)), stamp + step);
  endtask

  // Readout; byte and time carry junk
  task automatic send_readout();
    gdbc_pkg::in_item_t item;
    item.cmd     = gdbc_pkg::CMD_READOUT;
    item.rx_byte = 8'($urandom_range(255));
    item.time_ms = $urandom();
    send_request(item);
  endtask

  // Pause until every result is in, then let queued captures finish
  task automatic wait_results_drained();
    while (chunk_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_gap(logic [15:0] value);
    gap_we    = 1'b1;
    gap_wdata = value;
    @(negedge clk_i);
    gap_we  = 1'b0;
    gap_reg = value;
  endtask

  // Empty readout, gap boundary across time wrap, chunk split, second burst
  task automatic test_reset_and_chunking();
    send_readout();
    send_capture_at(8'h00, 32'hFFFF_FFF0);
    send_capture_at(8'hFF, 32'h0000_0004);
    repeat (17) send_capture(1'b0, 1'b0);
    send_capture(1'b1, 1'b1);
    repeat (3) send_readout();
  endtask

  // Gap register extremes with boundary steps
  task automatic test_gap_register();
    logic [15:0] settings [4];
    settings = '{16'd0, 16'hFFFF, 16'd1, gdbc_pkg::GAP_MS_RESET};
    foreach (settings[k]) begin
      wait_results_drained();
      write_gap(settings[k]);
      send_capture(1'b0, 1'b1);
      send_capture(1'b0, 1'b0);
      send_capture(1'b1, 1'b1);
      send_readout();
      send_readout();
    end
  endtask

  // Mixed captures and readouts, gap rewritten between phases
  task automatic test_random_traffic();
    int unsigned r;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n != 0 && n % 70 == 0) begin
        wait_results_drained();
        write_gap(($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                            : 16'($urandom_range(50)));
      end
      no_idle = (n >= 140 && n < 180);
      r = $urandom_range(99);
      if (r < 55)
        send_capture(n_bursts < 50 && $urandom_range(9) == 0, $urandom_range(3) == 0);
      else if (r < 60 && n_bursts < 50)
        send_capture_at(8'($urandom_range(255)), $urandom());
      else
        send_readout();
    end
    no_idle = 1'b0;
  endtask

  // Receiver holds off while readouts keep coming, then the sender waits
  task automatic test_output_backpressure();
    no_idle      = 1'b1;
    hold_off_req = 1'b1;
    repeat (8) send_readout();
    no_idle = 1'b0;
    wait_results_drained();
  endtask

  // Fill the burst table, then overflow it so bytes without a burst drop
  task automatic test_capture_overflow();
    wait_results_drained();
    write_gap(16'd100);
    while (n_bursts < SLOTS - 1) send_capture(1'b1, 1'b0);
    send_capture(1'b1, 1'b1);
    repeat (3) send_capture(1'b0, 1'b0);
    send_capture(1'b1, 1'b0);
    send_capture(1'b0, 1'b0);
    repeat (4) send_readout();
  endtask

  // Output channel ready with random stalls and one long hold-off
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        res_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      if (stall_left != 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = 1'b1;
        stall_left   = pick_gap();
      end
    end
  end

  // Compare each result with the oldest expectation
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin
    gdbc_pkg::out_item_t got, want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      if (chunk_results_q.size() == 0) begin
        $error("result with nothing expected: data_valid=%0b last=%0b",
               got.data_valid, got.last);
        failures++;
      end else begin
        want = chunk_results_q.pop_front();
        check_field("data_valid", want.data_valid, got.data_valid);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("burst_number", want.burst_number, got.burst_number);
        check_field("burst_start_ms", want.burst_start_ms, got.burst_start_ms);
        check_field("byte_offset", want.byte_offset, got.byte_offset);
        check_field("burst_length", want.burst_length, got.burst_length);
        check_field("recv_count", want.recv_count, got.recv_count);
        check_field("stored_count", want.stored_count, got.stored_count);
        check_field("burst_total", want.burst_total, got.burst_total);
        check_field("byte_lost", want.byte_lost, got.byte_lost);
        check_field("burst_lost", want.burst_lost, got.burst_lost);
        check_field("last", want.last, got.last);
      end
    end
  end

  // Watchdog on cycles with no request moving on either channel
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_and_chunking();
    test_gap_register();
    test_random_traffic();
    test_output_backpressure();
    test_capture_overflow();
    wait_results_drained();

    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/gdbc_pkg.sv
design/gdbc_stream_if.sv
design/gdbc_front.sv
design/gdbc_back.sv
design/gap_delimited_burst_capture_core.sv
test/gap_delimited_burst_capture_core_test.sv
